// File: rtl/core/ctn_pkg.sv
// Shared types, constants and the byte normalizer function for the text normalizer.
package ctn_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_HEX_EN    = 2'd0;
  localparam logic [1:0] REG_FOLD_CASE = 2'd1;
  localparam logic [1:0] REG_VIEW      = 2'd2;

  // View codes
  localparam logic [1:0] VIEW_RAW     = 2'd0;
  localparam logic [1:0] VIEW_STRIP   = 2'd1;
  localparam logic [1:0] VIEW_BRACKET = 2'd2;

  // Character codes
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_PERCENT = 8'd37;
  localparam logic [7:0] CH_LT      = 8'd60;
  localparam logic [7:0] CH_GT      = 8'd62;
  localparam logic [7:0] CASE_DELTA = 8'd32;

  // Decoded bytes per item and group queue depth
  localparam int GRP_BYTES = 3;
  localparam int Q_DEPTH   = 2;

  // One accepted item after escape decoding
  typedef struct packed {
    logic [GRP_BYTES-1:0][7:0] data;
    logic [1:0]                cnt;
    logic                      fin;
  } grp_t;

  // One result item
  typedef struct packed {
    logic [7:0] data;
    logic       bv;
    logic       eob;
  } res_t;

  // Result of normalizing one decoded byte
  typedef struct packed {
    logic       emit;
    logic [7:0] data;
    logic       in_tag;
    logic       prev_sp;
  } norm_t;

  // Fold, map punctuation and apply the selected view to one byte
  function automatic norm_t ctn_normalize(input logic [7:0] b, input logic fold,
                                          input logic [1:0] view, input logic in_tag,
                                          input logic prev_sp);
    logic [7:0] c;
    logic       punct;
    norm_t      r;
    c = b;
    if (fold && ((c inside {[8'd65:8'd90]}) || (c inside {[8'd192:8'd221]}))) begin
      c = c + CASE_DELTA;
    end
    if (view == VIEW_STRIP || view == VIEW_BRACKET) begin
      punct = (c < 8'd46) || (c inside {8'd58, 8'd59, 8'd63}) || (c inside {[8'd91:8'd96]});
    end else begin
      punct = (c < 8'd46) || (c inside {[8'd58:8'd64]}) || (c inside {[8'd91:8'd96]});
    end
    if (punct) begin
      c = CH_SPACE;
    end
    r.in_tag  = in_tag;
    r.prev_sp = prev_sp;
    r.emit    = 1'b1;
    if (view == VIEW_BRACKET) begin
      if (c == CH_LT || c == CH_GT) begin
        c = CH_SPACE;
      end
    end else if (view == VIEW_STRIP) begin
      if (c == CH_LT) begin
        r.in_tag = 1'b1;
      end
      if (c == CH_GT) begin
        r.in_tag = 1'b0;
        c = CH_SPACE;
      end
      if (r.in_tag) begin
        r.emit = 1'b0;
      end else if (c == CH_SPACE && prev_sp) begin
        r.emit = 1'b0;
      end else begin
        r.prev_sp = (c == CH_SPACE);
      end
    end
    r.data = c;
    return r;
  endfunction

endpackage

// File: rtl/core/ctn_front.sv
// Front end: accepts body bytes and decodes percent escapes into byte groups.
module ctn_front import ctn_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_is_final,
  input  logic       hex_en,
  input  logic       q_full,
  output logic       q_push,
  output grp_t       q_data
);

  logic [1:0] held_cnt_r, held_cnt_nxt;
  logic [7:0] held_sec_r, held_sec_nxt;
  logic       accept;

  function automatic logic is_hex(input logic [7:0] c);
    return (c inside {[8'd48:8'd57]}) || (c inside {[8'd97:8'd102]}) ||
           (c inside {[8'd65:8'd70]});
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c inside {[8'd48:8'd57]}) begin
      v = c - 8'd48;
    end else if (c inside {[8'd97:8'd102]}) begin
      v = c - 8'd87;
    end else if (c inside {[8'd65:8'd70]}) begin
      v = c - 8'd55;
    end
    return v[3:0];
  endfunction

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // Decode one byte against the held escape prefix
  always_comb begin : dec_p
    grp_t       g;
    logic [1:0] hc;
    logic [7:0] hs;
    g          = '0;
    hc         = held_cnt_r;
    hs         = held_sec_r;
    if (!hex_en) begin
      if (hc != 2'd0) begin
        g.data[g.cnt] = CH_PERCENT;
        g.cnt = g.cnt + 2'd1;
      end
      if (hc == 2'd2) begin
        g.data[g.cnt] = hs;
        g.cnt = g.cnt + 2'd1;
      end
      g.data[g.cnt] = in_byte;
      g.cnt = g.cnt + 2'd1;
      hc = 2'd0;
    end else if (hc == 2'd2 && is_hex(in_byte)) begin
      g.data[g.cnt] = {hex_val(hs), hex_val(in_byte)};
      g.cnt = g.cnt + 2'd1;
      hc = 2'd0;
    end else if (hc == 2'd1 && is_hex(in_byte)) begin
      hs = in_byte;
      hc = 2'd2;
    end else begin
      // release a failed prefix, then start over on the new byte
      if (hc != 2'd0) begin
        g.data[g.cnt] = CH_PERCENT;
        g.cnt = g.cnt + 2'd1;
      end
      if (hc == 2'd2) begin
        g.data[g.cnt] = hs;
        g.cnt = g.cnt + 2'd1;
      end
      if (in_byte == CH_PERCENT) begin
        hc = 2'd1;
      end else begin
        hc = 2'd0;
        g.data[g.cnt] = in_byte;
        g.cnt = g.cnt + 2'd1;
      end
    end
    // flush held bytes at end of body
    if (in_is_final) begin
      if (hc != 2'd0) begin
        g.data[g.cnt] = CH_PERCENT;
        g.cnt = g.cnt + 2'd1;
      end
      if (hc == 2'd2) begin
        g.data[g.cnt] = hs;
        g.cnt = g.cnt + 2'd1;
      end
      hc = 2'd0;
    end
    g.fin        = in_is_final;
    q_data       = g;
    held_cnt_nxt = accept ? hc : held_cnt_r;
    held_sec_nxt = accept ? hs : held_sec_r;
  end

  // Push only groups that carry bytes or end a body
  assign q_push = accept && (q_data.cnt != 2'd0 || q_data.fin);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_cnt_r <= 2'd0;
    end else begin
      held_cnt_r <= held_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_sec_r <= held_sec_nxt;
  end

endmodule

// File: rtl/core/ctn_queue.sv
// Two-entry group queue between the decoder front end and the normalizer back end.
module ctn_queue import ctn_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  grp_t push_data,
  output logic full,
  input  logic pop,
  output logic empty,
  output grp_t head
);

  localparam int PW = $clog2(Q_DEPTH);
  localparam int CW = $clog2(Q_DEPTH + 1);

  grp_t          mem_r [Q_DEPTH];
  logic [PW-1:0] wr_r, wr_nxt;
  logic [PW-1:0] rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CW'(Q_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PW'(Q_DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (pop) begin
      rd_nxt = (rd_r == PW'(Q_DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

endmodule

// File: rtl/core/ctn_back.sv
// Back end: normalizes a decoded group and hands its results out one per transfer.
module ctn_back import ctn_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fold,
  input  logic [1:0] view,
  input  logic       grp_valid,
  input  grp_t       grp,
  output logic       grp_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_end_of_body
);

  res_t [GRP_BYTES-1:0] slots_r, slots_nxt;
  logic [1:0]           cnt_r, cnt_nxt;
  logic                 tag_r, tag_nxt;
  logic                 psp_r, psp_nxt;

  res_t [GRP_BYTES-1:0] res;
  logic [1:0]           nres;
  logic                 g_tag, g_psp;
  logic                 out_xfer;

  assign out_valid       = (cnt_r != 2'd0);
  assign out_byte        = slots_r[0].data;
  assign out_byte_valid  = slots_r[0].bv;
  assign out_end_of_body = slots_r[0].eob;
  assign out_xfer        = out_valid && !out_stall;

  // Load a new group once the buffer drains
  assign grp_pop = grp_valid && (cnt_r == 2'd0 || (cnt_r == 2'd1 && out_xfer));

  // Normalize the head group in byte order
  always_comb begin : norm_p
    norm_t nr;
    nr    = '0;
    res   = '0;
    nres  = 2'd0;
    g_tag = tag_r;
    g_psp = psp_r;
    for (int k = 0; k < GRP_BYTES; k++) begin
      if (2'(k) < grp.cnt) begin
        nr    = ctn_normalize(grp.data[k], fold, view, g_tag, g_psp);
        g_tag = nr.in_tag;
        g_psp = nr.prev_sp;
        if (nr.emit) begin
          res[nres].data = nr.data;
          res[nres].bv   = 1'b1;
          nres           = nres + 2'd1;
        end
      end
    end
    // mark end of body, or send a bare end marker
    if (grp.fin) begin
      if (nres != 2'd0) begin
        res[nres - 2'd1].eob = 1'b1;
      end else begin
        res[0].eob = 1'b1;
        nres       = 2'd1;
      end
      g_tag = 1'b0;
      g_psp = 1'b1;
    end
  end

  // Load, or shift the buffer down on a transfer
  always_comb begin
    slots_nxt = slots_r;
    cnt_nxt   = cnt_r;
    tag_nxt   = tag_r;
    psp_nxt   = psp_r;
    if (grp_pop) begin
      slots_nxt = res;
      cnt_nxt   = nres;
      tag_nxt   = g_tag;
      psp_nxt   = g_psp;
    end else if (out_xfer) begin
      slots_nxt[0] = slots_r[1];
      slots_nxt[1] = slots_r[2];
      cnt_nxt      = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      tag_r <= 1'b0;
      psp_r <= 1'b1;
    end else begin
      cnt_r <= cnt_nxt;
      tag_r <= tag_nxt;
      psp_r <= psp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slots_r <= slots_nxt;
  end

endmodule

// File: rtl/core/content_text_normalizer.sv
// Top level of the percent-decoding text normalizer.
//
// Usage: body bytes enter on the in_ channel (in_valid / in_stall), one per
// transfer, with in_is_final on the last byte of a body. Normalized bytes
// leave on the out_ channel (out_valid / out_stall); out_byte_valid low means
// an end marker with no byte, out_end_of_body marks the last result of a body.
// Registers are written through cfg_we / cfg_index / cfg_wdata while idle.
// Each item is decoded into the group queue at its transfer, then normalized
// into the output buffer, from which its first result is offered. Throughput:
// one byte per cycle on both sides while the receiver does not stall and
// each item gives at most one result; an item that gives two or three
// results (a failed or flushed escape) holds the output buffer until all of
// them have left through the single output port. The two-entry group queue
// lets the decoder keep taking bytes while the receiver stalls, until the
// queue fills and in_stall rises.
// Reset: decoding off, case folding on, raw view, no held escape bytes,
// outside any tag and leading spaces suppressed.
module content_text_normalizer import ctn_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_is_final,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_end_of_body,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [1:0] cfg_wdata
);

  logic       hex_en_r;
  logic       fold_r;
  logic [1:0] view_r;

  logic q_push, q_full, q_pop, q_empty;
  grp_t q_in, q_head;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hex_en_r <= 1'b0;
      fold_r   <= 1'b1;
      view_r   <= VIEW_RAW;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEX_EN:    hex_en_r <= cfg_wdata[0];
        REG_FOLD_CASE: fold_r   <= cfg_wdata[0];
        REG_VIEW:      view_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  ctn_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .in_is_final (in_is_final),
    .hex_en      (hex_en_r),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_in)
  );

  ctn_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  ctn_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .fold            (fold_r),
    .view            (view_r),
    .grp_valid       (!q_empty),
    .grp             (q_head),
    .grp_pop         (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_end_of_body (out_end_of_body)
  );

endmodule

// File: sim/testbench.sv
// Self-checking testbench for the percent-decoding text normalizer.
`timescale 1ns / 1ps

module testbench;
  import ctn_pkg::*;

  // View code that the package leaves unnamed; behaves as the raw view
  localparam logic [1:0] VIEW_SPARE = 2'd3;

  typedef struct packed {
    logic [7:0] b;
    logic       fin;
  } body_item_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'd0;
  logic       in_is_final = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_byte_valid;
  logic       out_end_of_body;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = 2'd0;
  logic [1:0] cfg_wdata = 2'd0;

  content_text_normalizer uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte), .in_is_final(in_is_final),
    .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
    .out_byte_valid(out_byte_valid), .out_end_of_body(out_end_of_body),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Bytes waiting to be sent and normalized results still to arrive
  body_item_t pending_q[$];
  res_t       norm_out_q[$];

  // Predictor copy of the registers and the block state
  logic       mode_hex = 1'b0;
  logic       mode_fold = 1'b1;
  logic [1:0] mode_view = VIEW_RAW;
  logic [1:0] esc_held = 2'd0;
  logic [7:0] esc_pct = 8'd0;
  logic [7:0] esc_digit = 8'd0;
  logic       tag_open = 1'b0;
  logic       last_space = 1'b1;
  logic [7:0] dec_bytes [0:3];
  int         dec_cnt;

  // Run control and statistics
  logic       quiet = 1'b0;
  logic       long_hold_done = 1'b0;
  int         send_gap = 0;
  int         hold_left = 0;
  int         mismatches = 0;
  int         bytes_sent = 0;
  int         bodies = 0;
  int         escapes_decoded = 0;
  int         results_seen = 0;
  int         reg_writes = 0;
  int         input_held_cycles = 0;
  body_item_t drv_item;
  res_t       exp_res;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("testbench failed");
    $finish;
  end

  function automatic logic is_hex_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    if (c <= "9") begin
      return c[3:0];
    end
    return c[3:0] + 4'd9;
  endfunction

  task automatic keep_decoded(input logic [7:0] c);
    if (dec_cnt < 4) begin
      dec_bytes[dec_cnt] = c;
      dec_cnt++;
    end
  endtask

  task automatic release_escape();
    if (esc_held >= 2'd1) keep_decoded(esc_pct);
    if (esc_held >= 2'd2) keep_decoded(esc_digit);
    esc_held = 2'd0;
  endtask

  task automatic open_byte(input logic [7:0] c);
    if (c == CH_PERCENT) begin
      esc_pct = c;
      esc_held = 2'd1;
    end else begin
      keep_decoded(c);
    end
  endtask

  // Fold case, map punctuation to spaces and apply the view to one decoded byte
  task automatic fold_and_map(input logic [7:0] b, output logic emit, output logic [7:0] c);
    logic punct;
    c = b;
    emit = 1'b1;
    if (mode_fold && ((c >= 8'd65 && c <= 8'd90) || (c >= 8'd192 && c <= 8'd221))) begin
      c = c + CASE_DELTA;
    end
    if (mode_view == VIEW_STRIP || mode_view == VIEW_BRACKET) begin
      punct = c < 8'd46 || c == 8'd58 || c == 8'd59 || c == 8'd63 || (c > 8'd90 && c < 8'd97);
    end else begin
      punct = c < 8'd46 || (c > 8'd57 && c < 8'd65) || (c > 8'd90 && c < 8'd97);
    end
    if (punct) c = CH_SPACE;
    if (mode_view == VIEW_BRACKET) begin
      if (c == CH_LT || c == CH_GT) c = CH_SPACE;
    end else if (mode_view == VIEW_STRIP) begin
      if (c == CH_LT) tag_open = 1'b1;
      if (c == CH_GT) begin
        tag_open = 1'b0;
        c = CH_SPACE;
      end
      if (tag_open) begin
        emit = 1'b0;
      end else if (c == CH_SPACE && last_space) begin
        emit = 1'b0;
      end else begin
        last_space = (c == CH_SPACE);
      end
    end
  endtask

  // Decode one body byte and queue the normalized results it produces
  task automatic normalize_body_byte(input logic [7:0] b, input logic fin);
    res_t       outs [0:2];
    int         nout;
    int         k;
    logic       emit;
    logic [7:0] c;
    dec_cnt = 0;
    nout = 0;
    if (!mode_hex) begin
      release_escape();
      keep_decoded(b);
    end else if (esc_held == 2'd0) begin
      open_byte(b);
    end else if (esc_held == 2'd1) begin
      if (is_hex_char(b)) begin
        esc_digit = b;
        esc_held = 2'd2;
      end else begin
        release_escape();
        open_byte(b);
      end
    end else begin
      if (is_hex_char(b)) begin
        keep_decoded({hex_nibble(esc_digit), hex_nibble(b)});
        esc_held = 2'd0;
        escapes_decoded++;
      end else begin
        release_escape();
        open_byte(b);
      end
    end
    if (fin) release_escape();
    for (k = 0; k < dec_cnt && nout < 3; k++) begin
      fold_and_map(dec_bytes[k], emit, c);
      if (emit) begin
        outs[nout].data = c;
        outs[nout].bv = 1'b1;
        outs[nout].eob = 1'b0;
        nout++;
      end
    end
    // Mark the end of the body, with a bare marker when nothing came out
    if (fin) begin
      if (nout > 0) begin
        outs[nout-1].eob = 1'b1;
      end else begin
        outs[0].data = 8'd0;
        outs[0].bv = 1'b0;
        outs[0].eob = 1'b1;
        nout = 1;
      end
      esc_held = 2'd0;
      tag_open = 1'b0;
      last_space = 1'b1;
    end
    for (k = 0; k < nout; k++) norm_out_q.insert(norm_out_q.size(), outs[k]);
  endtask

  // Sender: hold the payload while stalled, advance on each transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_stall) input_held_cycles++;
      if (in_valid && !in_stall) begin
        normalize_body_byte(in_byte, in_is_final);
        bytes_sent++;
        if (!quiet && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 4);
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap--;
        end else if (pending_q.size() != 0) begin
          drv_item = pending_q.pop_front();
          in_valid <= 1'b1;
          in_byte <= drv_item.b;
          in_is_final <= drv_item.fin;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each transfer against the oldest prediction, then pick the next stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (norm_out_q.size() == 0) begin
          $error("result with nothing pending: out_byte %0d", out_byte);
          mismatches++;
        end else begin
          exp_res = norm_out_q.pop_front();
          if (out_byte !== exp_res.data) begin
            $error("out_byte: expected %0d, got %0d", exp_res.data, out_byte);
            mismatches++;
          end
          if (out_byte_valid !== exp_res.bv) begin
            $error("out_byte_valid: expected %0d, got %0d", exp_res.bv, out_byte_valid);
            mismatches++;
          end
          if (out_end_of_body !== exp_res.eob) begin
            $error("out_end_of_body: expected %0d, got %0d", exp_res.eob, out_end_of_body);
            mismatches++;
          end
        end
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (!quiet && !long_hold_done && results_seen >= 30 && pending_q.size() >= 15) begin
        // long hold-off so the group queue fills and the input stalls
        long_hold_done = 1'b1;
        hold_left = 39;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(0, 3);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic add_byte(input logic [7:0] b, input logic fin);
    body_item_t it;
    it.b = b;
    it.fin = fin;
    pending_q.insert(pending_q.size(), it);
  endtask

  task automatic add_text(input string s, input logic fin_last);
    int i;
    for (i = 0; i < s.len(); i++) add_byte(s[i], fin_last && (i == s.len() - 1));
    if (fin_last) bodies++;
  endtask

  // Wait until every byte is sent and every result is back, then let held work settle
  task automatic wait_drained();
    do @(negedge clk); while (pending_q.size() != 0 || in_valid || norm_out_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    reg_writes++;
    case (idx)
      REG_HEX_EN:    mode_hex = val[0];
      REG_FOLD_CASE: mode_fold = val[0];
      REG_VIEW:      mode_view = val;
      default: ;
    endcase
  endtask

  task automatic set_mode(input logic hex, input logic fold, input logic [1:0] view);
    write_reg(REG_HEX_EN, {1'b0, hex});
    write_reg(REG_FOLD_CASE, {1'b0, fold});
    write_reg(REG_VIEW, view);
    @(negedge clk);
  endtask

  function automatic logic [7:0] rand_hex_char();
    int r;
    r = $urandom_range(0, 21);
    if (r < 10) return 8'(r) + "0";
    if (r < 16) return 8'(r - 10) + "a";
    return 8'(r - 16) + "A";
  endfunction

  function automatic logic [7:0] rand_letter();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(0, 25)) + "A";
      1: return 8'($urandom_range(192, 223));
      default: return 8'($urandom_range(0, 25)) + "a";
    endcase
  endfunction

  // Build one body from escapes, tags, words, punctuation and noise
  task automatic gen_body();
    logic [7:0] bytes_q[$];
    int pieces;
    int p;
    int j;
    pieces = $urandom_range(1, 5);
    for (p = 0; p < pieces; p++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          bytes_q.insert(bytes_q.size(), CH_PERCENT);
          bytes_q.insert(bytes_q.size(), rand_hex_char());
          bytes_q.insert(bytes_q.size(), rand_hex_char());
        end
        3: begin
          bytes_q.insert(bytes_q.size(), CH_PERCENT);
          if ($urandom_range(0, 1)) bytes_q.insert(bytes_q.size(), rand_hex_char());
          bytes_q.insert(bytes_q.size(), 8'($urandom_range(0, 255)));
        end
        4: begin
          bytes_q.insert(bytes_q.size(), CH_LT);
          for (j = $urandom_range(1, 3); j > 0; j--) bytes_q.insert(bytes_q.size(), rand_letter());
          bytes_q.insert(bytes_q.size(), CH_GT);
        end
        5, 6: begin
          for (j = $urandom_range(1, 4); j > 0; j--) bytes_q.insert(bytes_q.size(), rand_letter());
        end
        7: bytes_q.insert(bytes_q.size(), 8'($urandom_range(32, 64)));
        default: bytes_q.insert(bytes_q.size(), 8'($urandom_range(0, 255)));
      endcase
    end
    for (j = 0; j < bytes_q.size(); j++) add_byte(bytes_q[j], j == bytes_q.size() - 1);
    bodies++;
  endtask

  task automatic run_random_phase(input logic hex, input logic fold, input logic [1:0] view,
                                  input logic last_phase);
    int added;
    wait_drained();
    set_mode(hex, fold, view);
    if (last_phase) quiet = 1'b1;
    added = pending_q.size();
    while (pending_q.size() - added < 22) gen_body();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: raw view, folding on, no decoding; byte extremes and fold bounds
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte("Z", 1'b0);
    add_byte(8'd221, 1'b0);
    add_byte(8'd192, 1'b1);
    bodies++;
    wait_drained();

    // Tag stripping with leading space, failed escapes re-examined, escape at body end
    set_mode(1'b1, 1'b0, VIEW_STRIP);
    add_text(" <a>%4G%%41", 1'b1);
    add_byte(CH_LT, 1'b1);
    bodies++;
    add_text("%4", 1'b0);
    wait_drained();

    // Decoding off while two bytes are held: they come out ahead of the next byte
    set_mode(1'b0, 1'b1, VIEW_BRACKET);
    add_byte("x", 1'b0);
    add_byte(CH_GT, 1'b1);
    bodies++;
    wait_drained();

    // Spare view acts raw; the final byte flushes a half escape
    set_mode(1'b1, 1'b1, VIEW_SPARE);
    add_text("%4", 1'b1);

    run_random_phase(1'b1, 1'b1, VIEW_STRIP, 1'b0);
    run_random_phase(1'b1, 1'b0, VIEW_BRACKET, 1'b0);
    run_random_phase(1'b0, 1'b1, VIEW_RAW, 1'b0);
    run_random_phase(1'b0, 1'b0, VIEW_STRIP, 1'b0);
    run_random_phase(1'b1, 1'b0, VIEW_SPARE, 1'b0);
    run_random_phase(1'b1, 1'b1, VIEW_RAW, 1'b1);

    wait_drained();
    repeat (10) @(posedge clk);

    $display("covered %0d body bytes in %0d bodies, %0d escapes decoded, %0d results checked",
             bytes_sent, bodies, escapes_decoded, results_seen);
    $display("%0d register writes across all views, input held off for %0d cycles",
             reg_writes, input_held_cycles);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
